// ===== hdl/ehcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehcw_pkg
// Shared types and constants for the IPv6 extension header chain walk.
// ----------------------------------------------------------------------------
package ehcw_pkg;

   localparam int LENGTH_BITS     = 16;
   localparam int TOTAL_BITS      = LENGTH_BITS + 1;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_ADDR_BITS = $clog2(QUEUE_DEPTH);

   // next-header codes that continue the chain
   localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
   localparam logic [7:0] NH_ROUTING    = 8'd43;
   localparam logic [7:0] NH_FRAGMENT   = 8'd44;
   localparam logic [7:0] NH_AUTH       = 8'd51;
   localparam logic [7:0] NH_DEST_OPTS  = 8'd60;

   localparam logic [5:0]  BASE_NH_OFFSET = 6'd6;
   localparam logic [11:0] BASE_SIZE      = 12'd40;
   localparam logic [11:0] EXT_MIN_SIZE   = 12'd8;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_TRUNC    = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      status_type             status;
      logic [7:0]             protocol;
      logic [LENGTH_BITS-1:0] length;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [15:0] sat16(input logic [LENGTH_BITS-1:0] value);
      logic [31:0] wide;
      wide = 32'(value);
      return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
   endfunction

endpackage

// ===== hdl/ehcw_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehcw_walk
// Front end: tracks the header chain one byte per accepted cycle and raises at most
// one result event per byte.
// ----------------------------------------------------------------------------
module ehcw_walk (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           packet_byte,
   input  logic                 end_of_packet,
   output logic                 event_valid,
   output ehcw_pkg::result_type event_data
);

   typedef enum logic [1:0] {
      KIND_BASE = 2'd0,
      KIND_EXT  = 2'd1,
      KIND_AH   = 2'd2,
      KIND_FRAG = 2'd3
   } kind_type;

   kind_type                         kind_ff, kind_in;
   logic [11:0]                      offset_ff, offset_in;
   logic [11:0]                      size_ff, size_in;
   logic [7:0]                       pending_ff, pending_in;
   logic [ehcw_pkg::LENGTH_BITS-1:0] skipped_ff, skipped_in;
   logic                             done_ff, done_in;

   logic [7:0]                       pending_cur;
   logic [11:0]                      size_cur;
   logic                             complete;
   logic [ehcw_pkg::TOTAL_BITS-1:0]  total;

   always_comb begin
      pending_cur = pending_ff;
      size_cur    = size_ff;
      if (kind_ff == KIND_BASE) begin
         if (offset_ff == 12'(ehcw_pkg::BASE_NH_OFFSET)) pending_cur = packet_byte;
      end else if (offset_ff == 12'd0) begin
         pending_cur = packet_byte;
      end else if (offset_ff == 12'd1) begin
         if (kind_ff == KIND_EXT) begin
            size_cur = {({1'b0, packet_byte} + 9'd1), 3'b000};
         end else if (kind_ff == KIND_AH) begin
            size_cur = {({2'b00, packet_byte} + 10'd2), 2'b00};
         end
      end
      complete = ({1'b0, offset_ff} + 13'd1) >= {1'b0, size_cur};
      total    = {1'b0, skipped_ff}
               + {{(ehcw_pkg::TOTAL_BITS - 12){1'b0}}, size_cur};
   end

   always_comb begin
      kind_in     = kind_ff;
      offset_in   = offset_ff;
      size_in     = size_ff;
      pending_in  = pending_ff;
      skipped_in  = skipped_ff;
      done_in     = done_ff;
      event_valid = 1'b0;
      event_data  = '{status: ehcw_pkg::STATUS_OK, protocol: 8'd0, length: skipped_ff};
      if (accept) begin
         if (!done_ff) begin
            pending_in = pending_cur;
            size_in    = size_cur;
            if (complete) begin
               if (total[ehcw_pkg::LENGTH_BITS]) begin
                  event_valid = 1'b1;
                  event_data  = '{status: ehcw_pkg::STATUS_OVERFLOW, protocol: 8'd0,
                                  length: '1};
                  done_in     = 1'b1;
               end else begin
                  skipped_in = total[ehcw_pkg::LENGTH_BITS-1:0];
                  offset_in  = 12'd0;
                  size_in    = ehcw_pkg::EXT_MIN_SIZE;
                  case (pending_cur) inside
                     ehcw_pkg::NH_HOP_BY_HOP, ehcw_pkg::NH_ROUTING,
                     ehcw_pkg::NH_DEST_OPTS: kind_in = KIND_EXT;
                     ehcw_pkg::NH_AUTH:      kind_in = KIND_AH;
                     ehcw_pkg::NH_FRAGMENT:  kind_in = KIND_FRAG;
                     default: begin
                        event_valid = 1'b1;
                        event_data  = '{status: ehcw_pkg::STATUS_OK,
                                        protocol: pending_cur,
                                        length: total[ehcw_pkg::LENGTH_BITS-1:0]};
                        done_in     = 1'b1;
                     end
                  endcase
               end
            end else begin
               offset_in = offset_ff + 12'd1;
            end
            // packet ended inside a header
            if (end_of_packet && !done_in) begin
               event_valid = 1'b1;
               event_data  = '{status: ehcw_pkg::STATUS_TRUNC, protocol: 8'd0,
                               length: skipped_in};
            end
         end
         if (end_of_packet) begin
            kind_in    = KIND_BASE;
            offset_in  = 12'd0;
            size_in    = ehcw_pkg::BASE_SIZE;
            pending_in = 8'd0;
            skipped_in = '0;
            done_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= KIND_BASE;
         offset_ff  <= 12'd0;
         size_ff    <= ehcw_pkg::BASE_SIZE;
         pending_ff <= 8'd0;
         skipped_ff <= '0;
         done_ff    <= 1'b0;
      end else begin
         kind_ff    <= kind_in;
         offset_ff  <= offset_in;
         size_ff    <= size_in;
         pending_ff <= pending_in;
         skipped_ff <= skipped_in;
         done_ff    <= done_in;
      end
   end

endmodule

// ===== hdl/ehcw_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehcw_queue
// Short result queue between the walk front end and the output stage.
// ----------------------------------------------------------------------------
module ehcw_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ehcw_pkg::result_type       push_data,
   input  logic                       pop,
   output ehcw_pkg::result_type       pop_data,
   output ehcw_pkg::queue_status_type status
);

   ehcw_pkg::result_type                entry_ff [ehcw_pkg::QUEUE_DEPTH];
   logic [ehcw_pkg::QUEUE_ADDR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ehcw_pkg::QUEUE_ADDR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ehcw_pkg::QUEUE_ADDR_BITS:0]   count_ff, count_in;
   logic                                 do_push, do_pop;

   assign status.full  = count_ff == (ehcw_pkg::QUEUE_ADDR_BITS + 1)'(ehcw_pkg::QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/ehcw_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehcw_emit
// Back end: pulls results from the queue, saturates the length and holds
// them in the output register until taken.
// ----------------------------------------------------------------------------
module ehcw_emit (
   input  logic                       clock,
   input  logic                       reset,
   input  ehcw_pkg::queue_status_type queue_status,
   input  ehcw_pkg::result_type       queue_data,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [23:0]                rsp_tdata,  // transport_protocol[7:0], headers_length[23:8]
   output logic [1:0]                 rsp_tuser   // walk_status[1:0]
);

   logic        valid_ff, valid_in;
   logic [23:0] data_ff, data_in;
   logic [1:0]  user_ff, user_in;

   assign pop = !queue_status.empty && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      user_in  = user_ff;
      if (pop) begin
         valid_in = 1'b1;
         data_in  = {ehcw_pkg::sat16(queue_data.length), queue_data.protocol};
         user_in  = queue_data.status;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

endmodule

// ===== hdl/ipv6_extension_header_chain_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_extension_header_chain_walk
// Walks the IPv6 base and extension header chain byte by byte and reports
// the transport protocol and skipped header length, or a truncation or
// overflow status.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_tvalid/tready    tdata = packet_byte, tlast = end_of_packet
//  rsp      out  rsp_tvalid/tready    tdata = protocol, length; tuser = status
//
//  One request per cycle while the queue is not full; each byte updates the walk in the cycle it is taken.
//  A result reaches rsp from its byte through the queue, then the output register.
//  Four-entry result queue; req_tready drops only while the queue is full.
//  Reset is synchronous and clears the walk, the queue and the output valid.
// ----------------------------------------------------------------------------
module ipv6_extension_header_chain_walk (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // packet_byte[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // transport_protocol[7:0], headers_length[23:8]
   output logic [1:0]  rsp_tuser    // walk_status[1:0]
);

   logic                       accept;
   logic                       event_valid;
   ehcw_pkg::result_type       event_data;
   logic                       pop;
   ehcw_pkg::result_type       queue_data;
   ehcw_pkg::queue_status_type queue_status;

   assign req_tready = !queue_status.full;
   assign accept     = req_tvalid && req_tready;

   ehcw_walk u_walk (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .packet_byte   (req_tdata),
      .end_of_packet (req_tlast),
      .event_valid   (event_valid),
      .event_data    (event_data)
   );

   ehcw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (event_valid),
      .push_data (event_data),
      .pop       (pop),
      .pop_data  (queue_data),
      .status    (queue_status)
   );

   ehcw_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .queue_data   (queue_data),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

   // a result event must never be dropped at a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      event_valid |-> !queue_status.full)
      else $error("result event raised while queue full");

   // events only arise from an accepted byte
   a_event_needs_accept: assert property (@(posedge clock) disable iff (reset)
      event_valid |-> accept)
      else $error("result event without accepted request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= ehcw_pkg::STATUS_OVERFLOW)
      else $error("undefined walk status on rsp");

   a_error_no_protocol: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ehcw_pkg::STATUS_OK) |-> rsp_tdata[7:0] == 8'd0)
      else $error("error result carries a protocol value");

endmodule
